[src/sha384_pkg.sv]
// package of types and constants for the sha-384 hash core
package sha384_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // state after a compression finishes
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_EMIT
    } t_ret;

    localparam int ROUNDS = 80;
    localparam int DIGEST_WORDS = 6;
    localparam logic [6:0] LEN_POS = 7'd112;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [63:0] t_word;

    // round constants
    function automatic t_word round_k(input logic [6:0] t);
        t_word k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    // initial hash values
    function automatic t_word init_h(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 64'hcbbb9d5dc1059ed8; 3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17; 3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31; 3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7; 3'd7: h = 64'h47b5481dbefa4fa4;
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

[src/sha384_if.sv]
// valid/ready channel interfaces for input words and digest words
interface sha384_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        final_word;
    modport source (output valid, message_word, valid_bytes, final_word, input ready);
    modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha384_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
    modport source (output valid, digest_word, digest_index, digest_last, input ready);
    modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

[src/sha384_round.sv]
// one sha-512 family round: shared datapath reused for all 80 rounds
module sha384_round (
    input  logic [511:0] i_regs,
    input  logic [63:0]  i_w,
    input  logic [63:0]  i_k,
    output logic [511:0] o_regs
);
    import sha384_pkg::*;

    t_word a, b, c, d, e, f, g, h, t1, t2, s0, s1, ch, mj;

    // unpack working variables, a in the top word
    always_comb begin
        {a, b, c, d, e, f, g, h} = i_regs;
        s1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + i_k + i_w;
        s0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
        mj = (a & b) ^ (a & c) ^ (b & c);
        t2 = s0 + mj;
        o_regs = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
endmodule

[src/sha384_sched.sv]
// message schedule expansion for one round
module sha384_sched (
    input  logic [63:0] i_w2,
    input  logic [63:0] i_w7,
    input  logic [63:0] i_w15,
    input  logic [63:0] i_w16,
    output logic [63:0] o_w
);
    import sha384_pkg::*;

    t_word sg0, sg1;

    // small sigma functions and sum
    always_comb begin
        sg1 = {i_w2[18:0], i_w2[63:19]} ^ {i_w2[60:0], i_w2[63:61]} ^ (i_w2 >> 6);
        sg0 = {i_w15[0], i_w15[63:1]} ^ {i_w15[7:0], i_w15[63:8]} ^ (i_w15 >> 7);
        o_w = sg1 + i_w7 + sg0 + i_w16;
    end
endmodule

[src/sha384_hash_core.sv]
// sha-384 hash core: byte packer, padding sequencer and iterative rounds
// Usage: message words arrive on the in channel (valid/ready); each word
// carries valid_bytes leading bytes (big-endian) and final_word marks the
// message end. Digest words leave on the out channel, six per message,
// index 0 first, digest_last on index 5.
// A non-final word that does not complete a 128-byte block leaves the input
// ready. A word that fills a block stalls the input through the rounds and
// through the fold of the round result into the chaining value; the single
// round datapath, used once per cycle, runs all the rounds. Bytes past the
// block end are held and placed in the next block during the fold.
// A final word then walks the padding one byte per cycle, with a
// compression for each block it closes (one or two), then offers the six
// digest words one per cycle while the receiver is ready.
// Reset (synchronous, i_rst_n low) loads the initial hash values and
// clears the length and fill counters. When the receiver stalls the out
// channel, the current digest word holds and the input stays not ready.
module sha384_hash_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha384_in_if.sink    in_ch,
    sha384_out_if.source out_ch
);
    import sha384_pkg::*;

    t_state       r_state, n_state;
    t_ret         r_ret, n_ret;
    t_word        r_h [8];
    t_word        r_w [16];
    logic [511:0] r_regs;
    logic [127:0] r_len;
    logic [6:0]   r_fill;
    logic [6:0]   r_rnd;
    logic [4:0]   r_padcnt;
    logic [2:0]   r_oidx;
    t_word        r_spill;

    logic [511:0] w_regs_next;
    t_word        w_sched, w_cur;
    logic [3:0]   w_nb;
    logic [3:0]   w_ti;
    logic [127:0] w_lenbytes_dummy;
    logic [7:0]   w_pad_byte;
    logic         w_take;
    t_word        w_pack_hi, w_pack_lo, w_spill;
    logic         w_lo_used;

    // saturate byte count
    assign w_nb = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
    assign w_ti = r_rnd[3:0];
    assign w_lenbytes_dummy = r_len;

    // schedule and round units
    sha384_sched u_sched (
        .i_w2 (r_w[w_ti - 4'd2]),
        .i_w7 (r_w[w_ti - 4'd7]),
        .i_w15(r_w[w_ti - 4'd15]),
        .i_w16(r_w[w_ti]),
        .o_w  (w_sched)
    );
    assign w_cur = (r_rnd < 7'd16) ? r_w[w_ti] : w_sched;

    sha384_round u_round (
        .i_regs(r_regs),
        .i_w   (w_cur),
        .i_k   (round_k(r_rnd)),
        .o_regs(w_regs_next)
    );

    // padding byte: 0x80, zeros, then the length bytes
    always_comb begin
        if (r_padcnt == 5'd0) begin
            w_pad_byte = PAD_BYTE;
        end else if (r_fill >= LEN_POS && r_padcnt[4]) begin
            w_pad_byte = w_lenbytes_dummy[8'd127 - {r_fill[3:0], 3'd0} -: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // place request bytes into the current word, the next word or the spill
    always_comb begin
        w_pack_hi = (r_fill[2:0] == 3'd0) ? '0 : r_w[r_fill[6:3]];
        w_pack_lo = '0;
        w_spill   = '0;
        w_lo_used = 1'b0;
        for (int j = 0; j < 8; j++) begin
            logic [7:0] pos;
            pos = {1'b0, r_fill} + 8'(j);
            if (4'(j) < w_nb) begin
                if (pos[7]) begin
                    w_spill[63 - 8*pos[2:0] -: 8] = in_ch.message_word[63 - 8*j -: 8];
                end else if (pos[6:3] == r_fill[6:3]) begin
                    w_pack_hi[63 - 8*pos[2:0] -: 8] = in_ch.message_word[63 - 8*j -: 8];
                end else begin
                    w_pack_lo[63 - 8*pos[2:0] -: 8] = in_ch.message_word[63 - 8*j -: 8];
                    w_lo_used = 1'b1;
                end
            end
        end
    end

    assign w_take = in_ch.valid & in_ch.ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if ({1'b0, r_fill} + {4'd0, w_nb} >= 8'd128) begin
                        n_state = ST_ROUND;
                        n_ret   = in_ch.final_word ? RET_PAD : RET_IDLE;
                    end else if (in_ch.final_word) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: if (r_rnd == 7'(ROUNDS - 1)) n_state = ST_FOLD;
            ST_FOLD: begin
                case (r_ret)
                    RET_PAD:  n_state = ST_PAD;
                    RET_EMIT: n_state = ST_EMIT;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                if (r_fill == 7'd127) begin
                    n_state = ST_ROUND;
                    n_ret   = (r_padcnt[4]) ? RET_EMIT : RET_PAD;
                end
            end
            ST_EMIT: begin
                if (out_ch.ready && r_oidx == 3'(DIGEST_WORDS - 1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ch.ready         = (r_state == ST_IDLE);
        out_ch.valid        = (r_state == ST_EMIT);
        out_ch.digest_word  = r_h[r_oidx];
        out_ch.digest_index = r_oidx;
        out_ch.digest_last  = (r_oidx == 3'(DIGEST_WORDS - 1));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= RET_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
            r_len    <= '0;
            r_fill   <= '0;
            r_rnd    <= '0;
            r_padcnt <= '0;
            r_oidx   <= '0;
            r_spill  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        // pack bytes into the window
                        if (w_nb != 4'd0) r_w[r_fill[6:3]] <= w_pack_hi;
                        if (w_lo_used) r_w[r_fill[6:3] + 4'd1] <= w_pack_lo;
                        r_spill <= w_spill;
                        r_fill <= r_fill + 7'(w_nb);
                        r_len  <= r_len + {121'd0, w_nb, 3'd0};
                        r_padcnt <= '0;
                        if ({1'b0, r_fill} + {4'd0, w_nb} >= 8'd128) begin
                            r_regs <= {r_h[0], r_h[1], r_h[2], r_h[3],
                                       r_h[4], r_h[5], r_h[6], r_h[7]};
                            r_rnd  <= '0;
                        end
                    end
                end
                ST_ROUND: begin
                    r_regs <= w_regs_next;
                    if (r_rnd >= 7'd16) r_w[w_ti] <= w_sched;
                    r_rnd <= r_rnd + 7'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_regs[511 - 64*i -: 64];
                    r_rnd <= '0;
                    // bytes past the block end start the next block
                    if (r_ret != RET_EMIT) r_w[0] <= r_spill;
                    if (r_ret == RET_EMIT) r_oidx <= '0;
                end
                ST_PAD: begin
                    // one padding byte per cycle
                    if (r_fill[2:0] == 3'd0) begin
                        r_w[r_fill[6:3]] <= {w_pad_byte, 56'd0};
                    end else begin
                        r_w[r_fill[6:3]][63 - 8*r_fill[2:0] -: 8] <= w_pad_byte;
                    end
                    r_fill <= r_fill + 7'd1;
                    if (r_fill == LEN_POS - 7'd1) begin
                        r_padcnt <= 5'h10;
                    end else if (r_padcnt == 5'd0) begin
                        r_padcnt <= 5'd1;
                    end
                    if (r_fill == 7'd127) begin
                        r_regs <= {r_h[0], r_h[1], r_h[2], r_h[3],
                                   r_h[4], r_h[5], r_h[6], r_h[7]};
                        r_rnd  <= '0;
                    end
                end
                ST_EMIT: begin
                    if (out_ch.ready) begin
                        if (r_oidx == 3'(DIGEST_WORDS - 1)) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
                            r_len  <= '0;
                            r_fill <= '0;
                            r_oidx <= '0;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[verif/sha384_test_if.sv]
// note: the channel interfaces live in src/sha384_if.sv and are reused as they are
`timescale 1ns / 100ps
package sha384_test_pkg;
    import sha384_pkg::*;

    // one expected digest word
    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_item;

    // scoreboard: bit-exact software sha-384 and the queue of digest words it predicts
    class sha384_scoreboard;
        t_word          chain[8];
        t_word          window[16];
        logic [127:0]   bit_count;
        int unsigned    fill;
        t_digest_item   pending_digest[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
            restart();
            for (int i = 0; i < 16; i++) window[i] = '0;
        endfunction

        function void restart();
            chain[0] = 64'hcbbb9d5dc1059ed8; chain[1] = 64'h629a292a367cd507;
            chain[2] = 64'h9159015a3070dd17; chain[3] = 64'h152fecd8f70e5939;
            chain[4] = 64'h67332667ffc00b31; chain[5] = 64'h8eb44a8768581511;
            chain[6] = 64'hdb0c2e0d64f98fa7; chain[7] = 64'h47b5481dbefa4fa4;
            bit_count = '0;
            fill = 0;
        endfunction

        function t_word rotr(t_word x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        // 80 rounds over the window, folded into the chaining value
        function void compress();
            t_word r[8];
            t_word w, w2, w15, t1, t2;
            for (int i = 0; i < 8; i++) r[i] = chain[i];
            for (int t = 0; t < 80; t++) begin
                if (t >= 16) begin
                    w2 = window[(t - 2) & 15];
                    w15 = window[(t - 15) & 15];
                    w = (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6)) + window[(t - 7) & 15]
                        + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + window[t & 15];
                    window[t & 15] = w;
                end else begin
                    w = window[t];
                end
                t1 = r[7] + (rotr(r[4], 14) ^ rotr(r[4], 18) ^ rotr(r[4], 41))
                    + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_k(t) + w;
                t2 = (rotr(r[0], 28) ^ rotr(r[0], 34) ^ rotr(r[0], 39))
                    + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
                r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
                r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += r[i];
        endfunction

        function void append_byte(logic [7:0] b);
            if (fill[2:0] == 0) window[fill >> 3] = '0;
            window[fill >> 3] |= t_word'(b) << (56 - 8 * fill[2:0]);
            fill++;
            if (fill == 128) begin
                compress();
                fill = 0;
            end
        endfunction

        // note one accepted request
        function void note_request(t_word data, logic [3:0] nbytes, logic fin);
            int unsigned n;
            logic [127:0] len;
            n = (nbytes > 8) ? 8 : nbytes;
            for (int i = 0; i < n; i++) append_byte(data[63 - 8 * i -: 8]);
            bit_count += 128'(n * 8);
            if (fin) begin
                len = bit_count;
                append_byte(8'h80);
                while (fill != 112) append_byte(8'h00);
                for (int i = 0; i < 16; i++) append_byte(len[127 - 8 * i -: 8]);
                for (int i = 0; i < 6; i++)
                    pending_digest.push_back('{chain[i], 3'(i), i == 5});
                restart();
            end
        endfunction

        // compare one accepted digest word with the oldest prediction
        function void check_digest(t_word word, logic [2:0] index, logic last);
            t_digest_item e;
            if (pending_digest.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time, word, index);
                mismatches++;
                return;
            end
            e = pending_digest.pop_front();
            if (e.word !== word || e.index !== index || e.last !== last) begin
                $display("%0t: expected %h idx %0d last %0d, actual %h idx %0d last %0d",
                         $time, e.word, e.index, e.last, word, index, last);
                mismatches++;
            end
        endfunction

        function t_word sha_k(int t);
            return round_k(7'(t));
        endfunction
    endclass
endpackage

[verif/sha384_hash_core_test.sv]
// top of the sha-384 core testbench: drives messages, checks digests
`timescale 1ns / 100ps
module sha384_hash_core_test;
    import sha384_pkg::*;
    import sha384_test_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sha384_in_if  in_ch();
    sha384_out_if out_ch();

    sha384_scoreboard digests = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    sha384_hash_core dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch));

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.message_word = '0;
        in_ch.valid_bytes = '0;
        in_ch.final_word = 1'b0;
        out_ch.ready = 1'b0;
    end

    // receiver with random stalls; checks every accepted digest word
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            digests.check_digest(out_ch.digest_word, out_ch.digest_index, out_ch.digest_last);
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // send one request, with random idle cycles first; valid stays up after acceptance
    task automatic send_word(input t_word data, input logic [3:0] nbytes, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.message_word <= data;
        in_ch.valid_bytes <= nbytes;
        in_ch.final_word <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        digests.note_request(data, nbytes, fin);
    endtask

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // one message of random content; mostly full words, some short or empty ones
    task automatic send_message(input int unsigned nwords);
        logic [3:0] nb;
        for (int i = 0; i < nwords; i++) begin
            nb = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
            send_word(rand_word(), nb, 1'b0);
        end
        send_word(rand_word(), 4'($urandom_range(15)), 1'b1);
    endtask

    initial begin
        int unsigned drain;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, "abc", extremes, padding boundaries
        send_word('0, 4'd0, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_word('1, 4'd8, 1'b0);
        send_word('1, 4'd0, 1'b0);
        send_word(64'h0123456789abcdef, 4'd5, 1'b0);
        send_word(64'hfedcba9876543210, 4'd9, 1'b1);
        for (int i = 0; i < 13; i++) send_word(~t_word'(i), 4'd8, 1'b0);
        send_word(64'haaaaaaaaaaaaaaaa, 4'd7, 1'b1);
        for (int i = 0; i < 14; i++) send_word(t_word'(i), 4'd8, 1'b0);
        send_word(64'h5555555555555555, 4'd0, 1'b1);

        // random messages across idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 60) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 60) : 0;
            for (int m = 0; m < 8; m++) begin
                send_message($urandom_range(($urandom_range(3) == 0) ? 34 : 6));
            end
        end
        in_ch.valid <= 1'b0;

        drain = 0;
        while (digests.pending_digest.size() != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (300) @(posedge i_clk);
        if (digests.pending_digest.size() == 0 && digests.mismatches == 0)
            $display("sha384_hash_core_test OK");
        else
            $display("sha384_hash_core_test NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("sha384_hash_core_test NOT OK");
        $finish;
    end
endmodule
